// ===== rtl/sgc_pkg.sv =====
`default_nettype none
package sgc_pkg;

  // Geometry of the generator
  localparam int DIMS      = 4;
  localparam int FRAC_BITS = 30;
  localparam int ROWS      = 30;
  localparam int PATH_W    = 32;
  localparam int DIM_W     = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int ROW_W     = $clog2(ROWS + 1);
  localparam int CFG_W     = 3;

  // Input field widths
  localparam int ACT_W   = 2;
  localparam int DSEL_W  = 2;
  localparam int RSEL_W  = 5;
  localparam int WORD_W  = 30;
  localparam int START_W = 30;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NEXT    = 2'd2;

  // Shared control that every cell sees
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [FRAC_BITS-1:0] word;
    logic                 restart_clr;
    logic                 restart_acc;
    logic                 acc_sel;
    logic                 snap;
    logic                 shift_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sgc_in_if.sv =====
`default_nettype none
interface sgc_in_if import sgc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [DSEL_W-1:0]  dim_select;
  logic [RSEL_W-1:0]  row_select;
  logic [WORD_W-1:0]  direction_word;
  logic [START_W-1:0] start_path;

  modport source (output valid, action, dim_select, row_select, direction_word, start_path,
                  input ready);
  modport sink   (input valid, action, dim_select, row_select, direction_word, start_path,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sgc_out_if.sv =====
`default_nettype none
interface sgc_out_if import sgc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           dim_index;
  logic [FRAC_BITS-1:0] fraction;
  logic                 last_of_point;
  logic                 error_flag;

  modport source (output valid, dim_index, fraction, last_of_point, error_flag,
                  input ready);
  modport sink   (input valid, dim_index, fraction, last_of_point, error_flag,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sobol_gray_code_generator_core.sv =====
// Load: writes one direction row entry, no result.
// Restart: accept, then one direction row per cycle over 30 rows, no result.
// Next point: accept, then one coordinate per cycle for each of n active dimensions, shifted out
// of the cell chain while the output is not stalled; an error step emits one error coordinate.
// Reset: path counter and point words to zero, direction rows read as zero, 4 dimensions.
`default_nettype none
module sobol_gray_code_generator_core import sgc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  sgc_in_if.sink                in_chan,
  sgc_out_if.source             out_chan
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RESTART = 2'd1;
  localparam logic [1:0] ST_EMIT    = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     dims_r;
  logic [DIM_W-1:0]     nm1;
  logic [PATH_W-1:0]    path_r, path_nxt, path_inc;
  logic [START_W-1:0]   gray_r, gray_nxt;
  logic [ROW_W-1:0]     rc_r, rc_nxt;
  logic [DIM_W-1:0]     cnt_r, cnt_nxt;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_dim_r;
  logic [FRAC_BITS-1:0] out_frac_r;
  logic                 out_last_r, out_err_r;

  logic                 accept, slot_free, emit, is_last;
  logic [ROW_W-1:0]     k;
  logic                 k_found;
  cell_ctrl_t           ctrl;
  logic [DIMS-1:0]      wr_en, upd_en;
  logic [FRAC_BITS-1:0] chain [DIMS+1];

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign path_inc      = path_r + PATH_W'(1);

  // Clamp the dimension count to 1..DIMS
  always_comb begin
    if (dims_r == '0) begin
      nm1 = '0;
    end else if (dims_r > CFG_W'(DIMS)) begin
      nm1 = DIM_W'(DIMS - 1);
    end else begin
      nm1 = DIM_W'(dims_r - CFG_W'(1));
    end
  end

  // Find the lowest set bit of the advanced path among its low ROWS bits
  always_comb begin
    k       = '0;
    k_found = 1'b0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (path_inc[i]) begin
        k       = ROW_W'(i);
        k_found = 1'b1;
      end
    end
  end

  // Cell control and per-cell enables
  always_comb begin
    ctrl.row         = rc_r;
    ctrl.word        = in_chan.direction_word[FRAC_BITS-1:0];
    ctrl.restart_clr = accept && (in_chan.action == ACT_RESTART);
    ctrl.restart_acc = (state_r == ST_RESTART);
    ctrl.acc_sel     = gray_r[0];
    ctrl.snap        = accept && (in_chan.action == ACT_NEXT) && k_found;
    ctrl.shift_en    = emit && !err_r;
    if (state_r == ST_IDLE) begin
      ctrl.row = (in_chan.action == ACT_NEXT) ? k : ROW_W'(in_chan.row_select);
    end
    for (int d = 0; d < DIMS; d++) begin
      wr_en[d]  = accept && (in_chan.action == ACT_LOAD)
                  && (in_chan.row_select < RSEL_W'(ROWS))
                  && (in_chan.dim_select == DSEL_W'(d));
      upd_en[d] = ctrl.snap && (DIM_W'(d) <= nm1);
    end
  end

  // Row of cells, one per dimension, shifting toward cell zero
  assign chain[DIMS] = '0;
  for (genvar d = 0; d < DIMS; d++) begin : g_cell
    sgc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wr_en     (wr_en[d]),
      .upd_en    (upd_en[d]),
      .shift_in  (chain[d+1]),
      .shift_out (chain[d])
    );
  end

  assign slot_free = !out_valid_r || out_chan.ready;
  assign emit      = (state_r == ST_EMIT) && slot_free;
  assign is_last   = err_r || (cnt_r == nm1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    path_nxt  = path_r;
    gray_nxt  = gray_r;
    rc_nxt    = rc_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_chan.action)
            ACT_RESTART: begin
              path_nxt  = PATH_W'(in_chan.start_path);
              gray_nxt  = in_chan.start_path ^ (in_chan.start_path >> 1);
              rc_nxt    = '0;
              state_nxt = ST_RESTART;
            end
            ACT_NEXT: begin
              path_nxt  = path_inc;
              cnt_nxt   = '0;
              err_nxt   = !k_found;
              state_nxt = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESTART: begin
        gray_nxt = gray_r >> 1;
        rc_nxt   = rc_r + ROW_W'(1);
        if (rc_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          cnt_nxt = cnt_r + DIM_W'(1);
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dims_r      <= CFG_W'(DIMS);
      path_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      rc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      path_r      <= path_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      rc_r        <= rc_nxt;
      if (cfg_wr_en) begin
        dims_r <= cfg_wr_data;
      end
    end
  end

  // Gray code of the restart index, consumed one bit a cycle
  always_ff @(posedge clk) begin
    gray_r <= gray_nxt;
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_dim_r  <= err_r ? 2'd0 : 2'(cnt_r);
      out_frac_r <= err_r ? '0 : chain[0];
      out_last_r <= is_last;
      out_err_r  <= err_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.dim_index     = out_dim_r;
  assign out_chan.fraction      = out_frac_r;
  assign out_chan.last_of_point = out_last_r;
  assign out_chan.error_flag    = out_err_r;

endmodule
`default_nettype wire

// ===== rtl/sgc_cell.sv =====
`default_nettype none
module sgc_cell import sgc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic                 wr_en,
  input  wire logic                 upd_en,
  input  wire logic [FRAC_BITS-1:0] shift_in,
  output logic      [FRAC_BITS-1:0] shift_out
);

  logic [FRAC_BITS-1:0] dir_r [ROWS];
  logic [ROWS-1:0]      vld_r;
  logic [FRAC_BITS-1:0] word_r, word_nxt;
  logic [FRAC_BITS-1:0] shift_r;
  logic [FRAC_BITS-1:0] rd;

  // Read the selected row; unwritten rows read as zero
  always_comb begin
    rd = '0;
    if (ctrl.row < ROW_W'(ROWS)) begin
      if (vld_r[ctrl.row]) begin
        rd = dir_r[ctrl.row];
      end
    end
  end

  // Next point word
  always_comb begin
    word_nxt = word_r;
    if (ctrl.restart_clr) begin
      word_nxt = '0;
    end else if (ctrl.restart_acc && ctrl.acc_sel) begin
      word_nxt = word_r ^ rd;
    end else if (upd_en) begin
      word_nxt = word_r ^ rd;
    end
  end

  // Direction column storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dir_r[ctrl.row] <= ctrl.word;
    end
  end

  // Row valid bits and point word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      word_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[ctrl.row] <= 1'b1;
      end
      word_r <= word_nxt;
    end
  end

  // Capture the new word, then pass it toward cell zero
  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      shift_r <= word_nxt;
    end else if (ctrl.shift_en) begin
      shift_r <= shift_in;
    end
  end

  assign shift_out = shift_r;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// One input transaction as the generator sees it
typedef struct packed {
  bit [sgc_pkg::ACT_W-1:0]   action;
  bit [sgc_pkg::DSEL_W-1:0]  dsel;
  bit [sgc_pkg::RSEL_W-1:0]  rsel;
  bit [sgc_pkg::WORD_W-1:0]  word;
  bit [sgc_pkg::START_W-1:0] start;
} sobol_req_t;

// One emitted coordinate
typedef struct packed {
  bit [1:0]                    dim;
  bit [sgc_pkg::FRAC_BITS-1:0] frac;
  bit                          last;
  bit                          err;
} coord_t;

// Tracks direction table, path counter and point words; queues the coordinates they produce
class sobol_scoreboard;
  bit [sgc_pkg::CFG_W-1:0]     dims_reg;
  bit [sgc_pkg::PATH_W-1:0]    path_cnt;
  bit [sgc_pkg::FRAC_BITS-1:0] point_word [sgc_pkg::DIMS];
  bit [sgc_pkg::FRAC_BITS-1:0] dir_row [sgc_pkg::ROWS][sgc_pkg::DIMS];
  coord_t                      coord_q [$];
  int                          mismatches;

  function new();
    dims_reg   = sgc_pkg::DIMS;
    path_cnt   = '0;
    mismatches = 0;
    foreach (point_word[d]) point_word[d] = '0;
    foreach (dir_row[r, d]) dir_row[r][d] = '0;
  endfunction

  function void set_dims(bit [sgc_pkg::CFG_W-1:0] v);
    dims_reg = v;
  endfunction

  // Zero acts as one, anything above the table width acts as the full width
  function int active_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > sgc_pkg::DIMS) return sgc_pkg::DIMS;
    return int'(dims_reg);
  endfunction

  function void note_input(sobol_req_t req);
    bit [sgc_pkg::START_W-1:0]   gray;
    bit [sgc_pkg::FRAC_BITS-1:0] acc;
    coord_t                      c;
    int                          k;
    int                          n;
    int                          d;
    int                          r;
    case (req.action)
      sgc_pkg::ACT_LOAD: begin
        if (req.rsel < sgc_pkg::ROWS && req.dsel < sgc_pkg::DIMS)
          dir_row[req.rsel][req.dsel] = req.word;
      end
      sgc_pkg::ACT_RESTART: begin
        // Rebuild every word from the Gray code of the start index
        gray     = req.start ^ (req.start >> 1);
        path_cnt = sgc_pkg::PATH_W'(req.start);
        for (d = 0; d < sgc_pkg::DIMS; d++) begin
          acc = '0;
          for (r = 0; r < sgc_pkg::ROWS; r++) begin
            if (gray[r]) acc ^= dir_row[r][d];
          end
          point_word[d] = acc;
        end
      end
      sgc_pkg::ACT_NEXT: begin
        path_cnt = path_cnt + 1;
        k = -1;
        for (r = sgc_pkg::ROWS - 1; r >= 0; r--) begin
          if (path_cnt[r]) k = r;
        end
        if (k < 0) begin
          // No set bit below the table height: single error coordinate, words kept
          c.dim  = '0;
          c.frac = '0;
          c.last = 1'b1;
          c.err  = 1'b1;
          coord_q.push_back(c);
        end else begin
          n = active_dims();
          for (d = 0; d < n; d++) begin
            point_word[d] ^= dir_row[k][d];
            c.dim  = d[1:0];
            c.frac = point_word[d];
            c.last = (d == n - 1);
            c.err  = 1'b0;
            coord_q.push_back(c);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [1:0] dim, logic [sgc_pkg::FRAC_BITS-1:0] frac,
                             logic last, logic err);
    coord_t want;
    if (coord_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected coordinate: dim %0d frac %h last %b err %b", dim, frac, last, err);
      return;
    end
    want = coord_q.pop_front();
    if (dim !== want.dim || frac !== want.frac || last !== want.last || err !== want.err) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("coordinate mismatch: expected dim %0d frac %h last %b err %b",
                 want.dim, want.frac, want.last, want.err);
        $display("                     actual   dim %0d frac %h last %b err %b",
                 dim, frac, last, err);
      end
    end
  endfunction
endclass

module tb;
  import sgc_pkg::*;

  localparam bit [ACT_W-1:0] ACT_NOP       = 2'd3;
  localparam int             SETTLE_CYCLES = 40;
  localparam int             IDLE_LIMIT    = 5000;
  localparam int             PHASE_ITEMS   = 38;
  localparam int             PHASES        = 8;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  sgc_in_if  in_chan ();
  sgc_out_if out_chan ();

  sobol_scoreboard sb;
  bit              in_calm;
  bit              out_calm;

  sobol_gray_code_generator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long; none at all while calm
  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Random content everywhere; builders below override what the action uses
  function automatic sobol_req_t noise_req();
    sobol_req_t req;
    req.action = ACT_W'($urandom_range(0, 3));
    req.dsel   = DSEL_W'($urandom);
    req.rsel   = RSEL_W'($urandom);
    req.word   = WORD_W'($urandom);
    req.start  = START_W'($urandom);
    return req;
  endfunction

  function automatic sobol_req_t mk_load(bit [DSEL_W-1:0] d, bit [RSEL_W-1:0] r,
                                         bit [WORD_W-1:0] w);
    sobol_req_t req;
    req        = noise_req();
    req.action = ACT_LOAD;
    req.dsel   = d;
    req.rsel   = r;
    req.word   = w;
    return req;
  endfunction

  function automatic sobol_req_t mk_restart(bit [START_W-1:0] s);
    sobol_req_t req;
    req        = noise_req();
    req.action = ACT_RESTART;
    req.start  = s;
    return req;
  endfunction

  function automatic sobol_req_t mk_next();
    sobol_req_t req;
    req        = noise_req();
    req.action = ACT_NEXT;
    return req;
  endfunction

  // Mostly steps and loads; restarts often land just below a power of two so the
  // next step reaches deep rows or runs off the table
  function automatic sobol_req_t rand_req();
    sobol_req_t req;
    int         pick;
    int         m;
    req  = noise_req();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.action = ACT_NEXT;
    end else if (pick < 80) begin
      req.action = ACT_LOAD;
      if ($urandom_range(0, 19) == 0) req.rsel = RSEL_W'($urandom_range(30, 31));
      else req.rsel = RSEL_W'($urandom_range(0, ROWS - 1));
    end else if (pick < 96) begin
      req.action = ACT_RESTART;
      case ($urandom_range(0, 2))
        0: req.start = START_W'($urandom);
        1: req.start = START_W'($urandom_range(0, 255));
        default: begin
          m = $urandom_range(1, 30);
          req.start = (30'd1 << m) - 30'd1 - 30'($urandom_range(0, 3));
        end
      endcase
    end else begin
      req.action = ACT_NOP;
    end
    return req;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send(sobol_req_t req);
    int gap;
    gap = gap_len(in_calm);
    if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.action         <= req.action;
    in_chan.dim_select     <= req.dsel;
    in_chan.row_select     <= req.rsel;
    in_chan.direction_word <= req.word;
    in_chan.start_path     <= req.start;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_input(req);
  endtask

  // Drop valid, drain all coordinates, then allow a restart to finish
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.coord_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(bit [CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_dims(v);
  endtask

  // Result side: random back-pressure
  initial begin
    int stall;
    int hold;
    out_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = gap_len(out_calm);
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      hold = $urandom_range(1, 6);
      repeat (hold) @(posedge clk);
    end
  end

  // Check every accepted coordinate
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.dim_index, out_chan.fraction,
                      out_chan.last_of_point, out_chan.error_flag);
  end

  // Abort when neither channel moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sobol_req_t       req;
    bit [CFG_W-1:0]   dims_plan [PHASES];
    int               ph;
    int               i;
    sb        = new();
    dims_plan = '{3'd1, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd6, 3'd4};
    in_chan.valid          <= 1'b0;
    in_chan.action         <= '0;
    in_chan.dim_select     <= '0;
    in_chan.row_select     <= '0;
    in_chan.direction_word <= '0;
    in_chan.start_path     <= '0;
    cfg_wr_en              <= 1'b0;
    cfg_wr_data            <= '0;
    rst_n                  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Step on the empty table, then fill corner rows and columns
    send(mk_next());
    send(mk_load(2'd0, 5'd0, 30'h3FFFFFFF));
    send(mk_load(2'd3, 5'd0, 30'h00000001));
    send(mk_load(2'd1, 5'd1, 30'h2AAAAAAA));
    send(mk_load(2'd2, 5'd1, 30'h15555555));
    send(mk_load(2'd3, 5'd29, 30'h3FFFFFFF));
    send(mk_load(2'd0, 5'd29, 30'h20000000));
    // Rows past the table are dropped
    send(mk_load(2'd1, 5'd30, 30'h3FFFFFFF));
    send(mk_load(2'd2, 5'd31, 30'h3FFFFFFF));
    send(mk_next());
    send(mk_next());
    send(mk_next());
    send(mk_restart(30'h0));
    send(mk_next());
    // Next step uses the top row
    send(mk_restart(30'h1FFFFFFF));
    send(mk_next());
    // Path runs off the table: error coordinate, then recover on the following step
    send(mk_restart(30'h3FFFFFFF));
    send(mk_next());
    send(mk_next());
    // Unknown action with every field set
    req        = '1;
    req.action = ACT_NOP;
    send(req);
    send(mk_restart(30'h15555555));
    send(mk_next());

    // Random traffic under each dimension count
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_dims(dims_plan[ph]);
      for (i = 0; i < PHASE_ITEMS; i++) send(rand_req());
    end
    settle();

    if (sb.mismatches == 0 && sb.coord_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
